/* sv/mpsm_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-pattern string matcher package
// Shared constants, operation and status codes, and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mpsm_pkg;

   // Default sizes of the automaton.
   localparam int NODES_DEFAULT    = 4096;
   localparam int ALPHABET_DEFAULT = 26;

   // Widths of the request and response fields.
   localparam int OP_W     = 2;
   localparam int CHAR_W   = 5;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;
   localparam int WORD_W   = 16;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_PAT_CHAR = 2'd0;
   localparam logic [OP_W-1:0] OP_PAT_END  = 2'd1;
   localparam logic [OP_W-1:0] OP_BUILD    = 2'd2;
   localparam logic [OP_W-1:0] OP_TEXT     = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PHASE = 2'd2;

   // Datapath command codes.
   localparam int CMD_W = 5;
   localparam logic [CMD_W-1:0] CMD_NONE      = 5'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 5'd1;
   localparam logic [CMD_W-1:0] CMD_ACC_OK    = 5'd2;
   localparam logic [CMD_W-1:0] CMD_ACC_FULL  = 5'd3;
   localparam logic [CMD_W-1:0] CMD_ACC_PHASE = 5'd4;
   localparam logic [CMD_W-1:0] CMD_END_DROP  = 5'd5;
   localparam logic [CMD_W-1:0] CMD_LD_RD     = 5'd6;
   localparam logic [CMD_W-1:0] CMD_LD_CHK    = 5'd7;
   localparam logic [CMD_W-1:0] CMD_END_RD    = 5'd8;
   localparam logic [CMD_W-1:0] CMD_END_WR    = 5'd9;
   localparam logic [CMD_W-1:0] CMD_RT_RD     = 5'd10;
   localparam logic [CMD_W-1:0] CMD_RT_PR     = 5'd11;
   localparam logic [CMD_W-1:0] CMD_BQ_RD     = 5'd12;
   localparam logic [CMD_W-1:0] CMD_BQ_U      = 5'd13;
   localparam logic [CMD_W-1:0] CMD_BQ_F      = 5'd14;
   localparam logic [CMD_W-1:0] CMD_G_U       = 5'd15;
   localparam logic [CMD_W-1:0] CMD_G_UW      = 5'd16;
   localparam logic [CMD_W-1:0] CMD_G_F       = 5'd17;
   localparam logic [CMD_W-1:0] CMD_BUILD_END = 5'd18;
   localparam logic [CMD_W-1:0] CMD_SC_RD     = 5'd19;
   localparam logic [CMD_W-1:0] CMD_SC_V      = 5'd20;
   localparam logic [CMD_W-1:0] CMD_WALK      = 5'd21;
   localparam logic [CMD_W-1:0] CMD_RESP      = 5'd22;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic [CMD_W-1:0] code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic bad_letter;
      logic phase;
      logic dropped;
      logic last_letter;
      logic queue_more;
      logic goto_zero;
      logic walk_stop;
   } flags_type;

endpackage

/* sv/mpsm_if.sv */
// ----------------------------------------------------------------------------
// Matcher channel interfaces
// Valid/ready channels for the request and the response of the matcher.
// ----------------------------------------------------------------------------
interface mpsm_req_if;
   logic                         valid;
   logic                         ready;
   logic [mpsm_pkg::OP_W-1:0]    op;
   logic [mpsm_pkg::CHAR_W-1:0]  char_code;

   modport source (output valid, output op, output char_code, input ready);
   modport sink (input valid, input op, input char_code, output ready);
endinterface

interface mpsm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mpsm_pkg::COUNT_W-1:0]   match_count;
   logic [mpsm_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output match_count, output status, input ready);
   modport sink (input valid, input match_count, input status, output ready);
endinterface

/* sv/mpsm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/mpsm_ctrl.sv */
// ----------------------------------------------------------------------------
// Matcher controller
// State machine that sequences the clearing pass, pattern loading, the
// breadth-first link build and the text scan, and holds the response valid.
// ----------------------------------------------------------------------------
module mpsm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [mpsm_pkg::OP_W-1:0]  req_op,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  mpsm_pkg::flags_type        flags,
   output mpsm_pkg::cmd_type          cmd
);

   localparam logic [4:0] S_CLR    = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_LD_RD  = 5'd2;
   localparam logic [4:0] S_LD_CHK = 5'd3;
   localparam logic [4:0] S_END_RD = 5'd4;
   localparam logic [4:0] S_END_WR = 5'd5;
   localparam logic [4:0] S_RT_RD  = 5'd6;
   localparam logic [4:0] S_RT_PR  = 5'd7;
   localparam logic [4:0] S_BQ_CHK = 5'd8;
   localparam logic [4:0] S_BQ_U   = 5'd9;
   localparam logic [4:0] S_BQ_F   = 5'd10;
   localparam logic [4:0] S_G_U    = 5'd11;
   localparam logic [4:0] S_G_UW   = 5'd12;
   localparam logic [4:0] S_G_F    = 5'd13;
   localparam logic [4:0] S_SC_RD  = 5'd14;
   localparam logic [4:0] S_SC_V   = 5'd15;
   localparam logic [4:0] S_WALK   = 5'd16;
   localparam logic [4:0] S_DONE   = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command.
   always_comb begin
      state_in     = state_ff;
      cmd.code     = mpsm_pkg::CMD_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLR: begin
            if (flags.clear_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.code = mpsm_pkg::CMD_CLEAR;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DONE;
               if (flags.bad_letter) begin
                  cmd.code = mpsm_pkg::CMD_ACC_PHASE;
               end else begin
                  unique case (req_op)
                     mpsm_pkg::OP_PAT_CHAR: begin
                        if (flags.phase) begin
                           cmd.code = mpsm_pkg::CMD_ACC_PHASE;
                        end else if (flags.dropped) begin
                           cmd.code = mpsm_pkg::CMD_ACC_FULL;
                        end else begin
                           cmd.code = mpsm_pkg::CMD_ACC_OK;
                           state_in = S_LD_RD;
                        end
                     end
                     mpsm_pkg::OP_PAT_END: begin
                        if (flags.phase) begin
                           cmd.code = mpsm_pkg::CMD_ACC_PHASE;
                        end else if (flags.dropped) begin
                           cmd.code = mpsm_pkg::CMD_END_DROP;
                        end else begin
                           cmd.code = mpsm_pkg::CMD_ACC_OK;
                           state_in = S_END_RD;
                        end
                     end
                     mpsm_pkg::OP_BUILD: begin
                        if (flags.phase) begin
                           cmd.code = mpsm_pkg::CMD_ACC_PHASE;
                        end else begin
                           cmd.code = mpsm_pkg::CMD_ACC_OK;
                           state_in = S_RT_RD;
                        end
                     end
                     default: begin
                        if (!flags.phase) begin
                           cmd.code = mpsm_pkg::CMD_ACC_PHASE;
                        end else begin
                           cmd.code = mpsm_pkg::CMD_ACC_OK;
                           state_in = S_SC_RD;
                        end
                     end
                  endcase
               end
            end
         end
         S_LD_RD: begin
            cmd.code = mpsm_pkg::CMD_LD_RD;
            state_in = S_LD_CHK;
         end
         S_LD_CHK: begin
            cmd.code = mpsm_pkg::CMD_LD_CHK;
            state_in = S_DONE;
         end
         S_END_RD: begin
            cmd.code = mpsm_pkg::CMD_END_RD;
            state_in = S_END_WR;
         end
         S_END_WR: begin
            cmd.code = mpsm_pkg::CMD_END_WR;
            state_in = S_DONE;
         end
         S_RT_RD: begin
            cmd.code = mpsm_pkg::CMD_RT_RD;
            state_in = S_RT_PR;
         end
         S_RT_PR: begin
            cmd.code = mpsm_pkg::CMD_RT_PR;
            state_in = flags.last_letter ? S_BQ_CHK : S_RT_RD;
         end
         S_BQ_CHK: begin
            if (flags.queue_more) begin
               cmd.code = mpsm_pkg::CMD_BQ_RD;
               state_in = S_BQ_U;
            end else begin
               cmd.code = mpsm_pkg::CMD_BUILD_END;
               state_in = S_DONE;
            end
         end
         S_BQ_U: begin
            cmd.code = mpsm_pkg::CMD_BQ_U;
            state_in = S_BQ_F;
         end
         S_BQ_F: begin
            cmd.code = mpsm_pkg::CMD_BQ_F;
            state_in = S_G_U;
         end
         S_G_U: begin
            cmd.code = mpsm_pkg::CMD_G_U;
            state_in = S_G_UW;
         end
         S_G_UW: begin
            cmd.code = mpsm_pkg::CMD_G_UW;
            state_in = S_G_F;
         end
         S_G_F: begin
            cmd.code = mpsm_pkg::CMD_G_F;
            state_in = flags.last_letter ? S_BQ_CHK : S_G_U;
         end
         S_SC_RD: begin
            cmd.code = mpsm_pkg::CMD_SC_RD;
            state_in = S_SC_V;
         end
         S_SC_V: begin
            cmd.code = mpsm_pkg::CMD_SC_V;
            state_in = flags.goto_zero ? S_DONE : S_WALK;
         end
         S_WALK: begin
            cmd.code = mpsm_pkg::CMD_WALK;
            state_in = flags.walk_stop ? S_DONE : S_WALK;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.code     = mpsm_pkg::CMD_RESP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // No request is taken before the memories are cleared.
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      !flags.clear_done |-> !req_ready)
      else $error("request taken during the clearing pass");

endmodule

/* sv/mpsm_dp.sv */
// ----------------------------------------------------------------------------
// Matcher datapath
// Trie, fail link, word count, visited and queue memories with the cursors,
// counters and totals that the controller's commands update.
// ----------------------------------------------------------------------------
module mpsm_dp #(
   parameter int NODES    = mpsm_pkg::NODES_DEFAULT,
   parameter int ALPHABET = mpsm_pkg::ALPHABET_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mpsm_pkg::cmd_type               cmd,
   output mpsm_pkg::flags_type             flags,
   input  logic [mpsm_pkg::OP_W-1:0]       req_op,
   input  logic [mpsm_pkg::CHAR_W-1:0]     req_char,
   output logic [mpsm_pkg::COUNT_W-1:0]    rsp_count,
   output logic [mpsm_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int NB = $clog2(NODES);
   localparam int LB = $clog2(ALPHABET);
   localparam int AB = NB + LB;
   localparam int WW = mpsm_pkg::WORD_W;
   localparam int CW = mpsm_pkg::COUNT_W;

   // Memory ports.
   logic          goto_we, fail_we, queue_we, count_we, visit_we;
   logic [AB-1:0] goto_waddr, goto_raddr;
   logic [NB-1:0] goto_wdata, goto_rdata;
   logic [NB-1:0] fail_waddr, fail_raddr, fail_wdata, fail_rdata;
   logic [NB-1:0] queue_waddr, queue_raddr, queue_wdata, queue_rdata;
   logic [NB-1:0] count_waddr, count_raddr;
   logic [WW-1:0] count_wdata, count_rdata;
   logic [NB-1:0] visit_waddr, visit_raddr;
   logic          visit_wdata, visit_rdata;

   // Registers.
   logic [mpsm_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic [NB-1:0]                 ins_ff, ins_in, scan_ff, scan_in, nt_ff, nt_in;
   logic [NB-1:0]                 u_ff, u_in, f_ff, f_in, v_ff, v_in;
   logic [NB:0]                   head_ff, head_in, tail_ff, tail_in;
   logic [LB-1:0]                 cnt_ff, cnt_in;
   logic [AB:0]                   clr_ff, clr_in;
   logic                          dropped_ff, dropped_in, phase_ff, phase_in;
   logic [CW-1:0]                 found_ff, found_in;
   logic [mpsm_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [CW-1:0]                 rsp_count_ff, rsp_count_in;
   logic [mpsm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [LB-1:0] letter;
   logic          tail_full;
   logic          clr_low;
   logic [CW:0]   sum;

   assign letter    = LB'(char_ff);
   assign tail_full = (tail_ff == (NB+1)'(NODES));
   assign clr_low   = (clr_ff < (AB+1)'(NODES));
   assign sum       = {1'b0, found_ff} + (CW+1)'(count_rdata);

   // Status towards the controller.
   assign flags.clear_done  = clr_ff[AB];
   assign flags.bad_letter  = (req_op == mpsm_pkg::OP_PAT_CHAR || req_op == mpsm_pkg::OP_TEXT)
                              && ({4'b0, req_char} >= 9'(ALPHABET));
   assign flags.phase       = phase_ff;
   assign flags.dropped     = dropped_ff;
   assign flags.last_letter = (cnt_ff == LB'(ALPHABET - 1));
   assign flags.queue_more  = (head_ff < tail_ff);
   assign flags.goto_zero   = (goto_rdata == '0);
   assign flags.walk_stop   = visit_rdata || (fail_rdata == '0);

   // Command decode: register updates and memory accesses.
   always_comb begin
      char_in = char_ff;  ins_in = ins_ff;  scan_in = scan_ff;  nt_in = nt_ff;
      u_in = u_ff;  f_in = f_ff;  v_in = v_ff;
      head_in = head_ff;  tail_in = tail_ff;  cnt_in = cnt_ff;  clr_in = clr_ff;
      dropped_in = dropped_ff;  phase_in = phase_ff;  found_in = found_ff;
      status_in = status_ff;  rsp_count_in = rsp_count_ff;  rsp_status_in = rsp_status_ff;
      goto_we = 1'b0;  goto_waddr = '0;  goto_wdata = '0;  goto_raddr = '0;
      fail_we = 1'b0;  fail_waddr = '0;  fail_wdata = '0;  fail_raddr = '0;
      queue_we = 1'b0; queue_waddr = '0; queue_wdata = '0; queue_raddr = '0;
      count_we = 1'b0; count_waddr = '0; count_wdata = '0; count_raddr = '0;
      visit_we = 1'b0; visit_waddr = '0; visit_wdata = 1'b0; visit_raddr = '0;
      unique case (cmd.code)
         mpsm_pkg::CMD_NONE: begin
         end
         mpsm_pkg::CMD_CLEAR: begin
            goto_we     = 1'b1;
            goto_waddr  = clr_ff[AB-1:0];
            count_we    = clr_low;
            count_waddr = clr_ff[NB-1:0];
            visit_we    = clr_low;
            visit_waddr = clr_ff[NB-1:0];
            clr_in      = clr_ff + 1'b1;
         end
         mpsm_pkg::CMD_ACC_OK: begin
            char_in   = req_char;
            status_in = mpsm_pkg::ST_OK;
            head_in   = '0;
            tail_in   = '0;
            cnt_in    = '0;
         end
         mpsm_pkg::CMD_ACC_FULL: begin
            status_in = mpsm_pkg::ST_FULL;
         end
         mpsm_pkg::CMD_ACC_PHASE: begin
            status_in = mpsm_pkg::ST_PHASE;
         end
         mpsm_pkg::CMD_END_DROP: begin
            status_in  = mpsm_pkg::ST_FULL;
            dropped_in = 1'b0;
            ins_in     = '0;
         end
         mpsm_pkg::CMD_LD_RD: begin
            goto_raddr = {ins_ff, letter};
         end
         mpsm_pkg::CMD_LD_CHK: begin
            // A missing child takes a new node unless the trie is full.
            if (goto_rdata != '0) begin
               ins_in = goto_rdata;
            end else if ((NB+1)'(nt_ff) + 1'b1 >= (NB+1)'(NODES)) begin
               dropped_in = 1'b1;
               status_in  = mpsm_pkg::ST_FULL;
            end else begin
               nt_in      = nt_ff + 1'b1;
               ins_in     = nt_ff + 1'b1;
               goto_we    = 1'b1;
               goto_waddr = {ins_ff, letter};
               goto_wdata = nt_ff + 1'b1;
            end
         end
         mpsm_pkg::CMD_END_RD: begin
            count_raddr = ins_ff;
         end
         mpsm_pkg::CMD_END_WR: begin
            count_we    = (count_rdata != '1);
            count_waddr = ins_ff;
            count_wdata = count_rdata + 1'b1;
            ins_in      = '0;
            dropped_in  = 1'b0;
         end
         mpsm_pkg::CMD_RT_RD: begin
            goto_raddr = {{NB{1'b0}}, cnt_ff};
         end
         mpsm_pkg::CMD_RT_PR: begin
            // Children of the root fail to the root and enter the queue.
            if (goto_rdata != '0 && !tail_full) begin
               fail_we     = 1'b1;
               fail_waddr  = goto_rdata;
               queue_we    = 1'b1;
               queue_waddr = tail_ff[NB-1:0];
               queue_wdata = goto_rdata;
               tail_in     = tail_ff + 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         mpsm_pkg::CMD_BQ_RD: begin
            queue_raddr = head_ff[NB-1:0];
         end
         mpsm_pkg::CMD_BQ_U: begin
            u_in       = queue_rdata;
            head_in    = head_ff + 1'b1;
            fail_raddr = queue_rdata;
         end
         mpsm_pkg::CMD_BQ_F: begin
            f_in   = fail_rdata;
            cnt_in = '0;
         end
         mpsm_pkg::CMD_G_U: begin
            goto_raddr = {u_ff, cnt_ff};
         end
         mpsm_pkg::CMD_G_UW: begin
            v_in       = goto_rdata;
            goto_raddr = {f_ff, cnt_ff};
         end
         mpsm_pkg::CMD_G_F: begin
            // A child gets its fail link; a missing child takes the fail's move.
            if (v_ff != '0) begin
               fail_we    = 1'b1;
               fail_waddr = v_ff;
               fail_wdata = goto_rdata;
               if (!tail_full) begin
                  queue_we    = 1'b1;
                  queue_waddr = tail_ff[NB-1:0];
                  queue_wdata = v_ff;
                  tail_in     = tail_ff + 1'b1;
               end
            end else begin
               goto_we    = 1'b1;
               goto_waddr = {u_ff, cnt_ff};
               goto_wdata = goto_rdata;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         mpsm_pkg::CMD_BUILD_END: begin
            ins_in     = '0;
            dropped_in = 1'b0;
            scan_in    = '0;
            phase_in   = 1'b1;
         end
         mpsm_pkg::CMD_SC_RD: begin
            goto_raddr = {scan_ff, letter};
         end
         mpsm_pkg::CMD_SC_V: begin
            scan_in     = goto_rdata;
            v_in        = goto_rdata;
            fail_raddr  = goto_rdata;
            count_raddr = goto_rdata;
            visit_raddr = goto_rdata;
         end
         mpsm_pkg::CMD_WALK: begin
            // Count an unvisited node once and follow its fail link.
            if (!visit_rdata) begin
               found_in    = sum[CW] ? '1 : sum[CW-1:0];
               visit_we    = 1'b1;
               visit_waddr = v_ff;
               visit_wdata = 1'b1;
               v_in        = fail_rdata;
               fail_raddr  = fail_rdata;
               count_raddr = fail_rdata;
               visit_raddr = fail_rdata;
            end
         end
         mpsm_pkg::CMD_RESP: begin
            rsp_count_in  = found_ff;
            rsp_status_in = status_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff     <= '0;
         scan_ff    <= '0;
         nt_ff      <= '0;
         clr_ff     <= '0;
         dropped_ff <= 1'b0;
         phase_ff   <= 1'b0;
         found_ff   <= '0;
         status_ff  <= mpsm_pkg::ST_OK;
      end else begin
         ins_ff     <= ins_in;
         scan_ff    <= scan_in;
         nt_ff      <= nt_in;
         clr_ff     <= clr_in;
         dropped_ff <= dropped_in;
         phase_ff   <= phase_in;
         found_ff   <= found_in;
         status_ff  <= status_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      u_ff          <= u_in;
      f_ff          <= f_in;
      v_ff          <= v_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      cnt_ff        <= cnt_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   // Memories.
   mpsm_ram #(.WIDTH(NB), .DEPTH(1 << AB)) u_goto (
      .clock(clock), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
      .raddr(goto_raddr), .rdata(goto_rdata));
   mpsm_ram #(.WIDTH(NB), .DEPTH(NODES)) u_fail (
      .clock(clock), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
      .raddr(fail_raddr), .rdata(fail_rdata));
   mpsm_ram #(.WIDTH(NB), .DEPTH(NODES)) u_queue (
      .clock(clock), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
      .raddr(queue_raddr), .rdata(queue_rdata));
   mpsm_ram #(.WIDTH(WW), .DEPTH(NODES)) u_count (
      .clock(clock), .we(count_we), .waddr(count_waddr), .wdata(count_wdata),
      .raddr(count_raddr), .rdata(count_rdata));
   mpsm_ram #(.WIDTH(1), .DEPTH(NODES)) u_visit (
      .clock(clock), .we(visit_we), .waddr(visit_waddr), .wdata(visit_wdata),
      .raddr(visit_raddr), .rdata(visit_rdata));

   // The node total only grows.
   a_nodes_grow: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> nt_ff >= $past(nt_ff))
      else $error("node total decreased");

   // Once built, the automaton stays in the matching phase.
   a_phase_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(phase_ff)) |-> phase_ff)
      else $error("matching phase left");

   // The running total never falls.
   a_found_grow: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> found_ff >= $past(found_ff))
      else $error("match total decreased");

endmodule

/* sv/multi_pattern_string_matcher.sv */
// ----------------------------------------------------------------------------
// Multi-pattern string matcher
// Aho-Corasick automaton over letter indices with a pattern load, a link
// build and a text scan that counts each loaded pattern once.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the trie, count and
// visited memories and takes no request until it ends. A pattern letter
// then reads the trie memory and follows or adds a child, and a pattern
// end reads the count memory and writes it back. A request that only
// reports an error status, or a letter of a dropped pattern, goes
// straight to its response. A text letter reads the trie memory and then
// walks the chain, one read for each node: the newly visited nodes and,
// at most once, an already visited node that ends the walk. Over a whole
// text each node is visited at most once. The build queues the children
// of the root letter by letter, then for each queued node reads its fail
// link and steps one letter at a time through the trie memory. One
// response follows every request, and a finished response waits in an
// output register while the next request is taken.
module multi_pattern_string_matcher #(
   parameter int NODES    = mpsm_pkg::NODES_DEFAULT,
   parameter int ALPHABET = mpsm_pkg::ALPHABET_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mpsm_req_if.sink   req_port,
   mpsm_rsp_if.source rsp_port
);

   mpsm_pkg::cmd_type   cmd;
   mpsm_pkg::flags_type flags;

   // Sequencer.
   mpsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_op    (req_port.op),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // Memories and arithmetic.
   mpsm_dp #(.NODES(NODES), .ALPHABET(ALPHABET)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .req_op     (req_port.op),
      .req_char   (req_port.char_code),
      .rsp_count  (rsp_port.match_count),
      .rsp_status (rsp_port.status)
   );

endmodule
